// ===== sv/jddq_pkg.sv =====
// Shared types and constants for the joystick dead zone and direction quantizer.
// Holds the sequencer state type, register and opcode codes, and the CORDIC arctangent table.
// No dependencies.
package jddq_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_SQR,
    S_SQD,
    S_DECIDE,
    S_VEC,
    S_DMUL,
    S_DSET,
    S_DIV,
    S_RSET,
    S_ROT,
    S_VEL,
    S_SQRT,
    S_TMX,
    S_TMY,
    S_TFIN,
    S_DONE
  } state_t;

  // Configuration register indexes
  localparam logic [2:0] REG_STICK_RADIUS = 3'd0;
  localparam logic [2:0] REG_DEAD_RADIUS  = 3'd1;
  localparam logic [2:0] REG_DPAD_ENABLE  = 3'd2;
  localparam logic [2:0] REG_SECTOR_COUNT = 3'd3;
  localparam logic [2:0] REG_AUTO_CENTER  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [10:0] STICK_RADIUS_RST = 11'd64;
  localparam logic [10:0] DEAD_RADIUS_RST  = 11'd0;
  localparam logic [4:0]  SECTOR_COUNT_RST = 5'd4;

  // Touch event codes
  localparam logic [1:0] OP_BEGAN   = 2'd0;
  localparam logic [1:0] OP_MOVED   = 2'd1;
  localparam logic [1:0] OP_ENDED   = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  // Rotation start value: inverse CORDIC gain in Q2.30
  localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;

  // Sector snap divider: dividend width and bit steps
  localparam int DIV_W     = 38;
  localparam int DIV_STEPS = 38;

  // Angle of atan(2^-i) in binary turns (2^32 = full circle)
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/joystick_deadzone_direction_quantizer.sv =====
// Joystick dead zone and direction quantizer, top level.
// Shared CORDIC, multiplier and compare-subtract units under one sequencer.
// Depends on jddq_pkg.
//
// Usage:
//   in_*  : one touch event per transaction (event kind in tuser, position in tdata).
//   out_* : one result per event: accepted flag in tuser, velocity and thumb in tdata.
//   cfg_* : register writes, always ready; write only while the block is idle.
// A rejected event or a point inside the dead radius skips the CORDIC. An analog point
// runs vectoring then rotation; a point clamped to the stick radius also scales the
// thumb by that radius, and in D-pad mode an unclamped point first takes its distance
// by square root. D-pad mode adds the sector snap divider (one quotient bit a cycle).
// The CORDIC step unit does one iteration a cycle, vectoring then rotation; the divider
// and square root are bit-serial. One event is in work at a time; in_tready is high
// only while the sequencer is idle, so the next event is taken only once the previous
// result has been moved to the output register.
// A finished result sits in the output register; the next event is taken meanwhile, and
// its own result waits in the last stage until the receiver has taken the previous one.
// Reset (rst_n low, synchronous) loads register defaults, clears the held velocity and
// thumb to zero and drops any pending result.
module joystick_deadzone_direction_quantizer #(
  parameter int COORD_WIDTH  = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // pos_x, pos_y (COORD_WIDTH bits each, signed), zero padded to bytes
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       in_tdata,
  // opcode
  input  logic [1:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // vel_x (16), vel_y (16), thumb_x, thumb_y (COORD_WIDTH each), zero padded to bytes
  output logic [((32+2*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // accepted
  output logic                                     out_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [2:0]                               cfg_addr,
  input  logic [10:0]                              cfg_data
);

  localparam int CW         = COORD_WIDTH;
  localparam int OUT_W      = ((32+2*COORD_WIDTH+7)/8)*8;
  localparam int DIST_W     = (CW + 8 > 19) ? CW + 8 : 19;
  localparam int XY_W       = (CW + 19 > 33) ? CW + 19 : 33;
  localparam int ZW         = 34;
  localparam int PW         = DIST_W + 1 + XY_W;
  localparam int CMP_W      = (2*CW > 22) ? 2*CW : 22;
  localparam int RW         = 2*CW + 16;
  localparam int SRC_W      = (RW > jddq_pkg::DIV_W) ? RW : jddq_pkg::DIV_W;
  localparam int SQ_W       = CW + 12;
  localparam int QW         = (CW + 8 > jddq_pkg::DIV_W) ? CW + 8 : jddq_pkg::DIV_W;
  localparam int SQRT_STEPS = CW + 8;

  localparam logic signed [ZW-1:0] Q_TURN = 34'sd1073741824;
  localparam logic signed [ZW-1:0] H_TURN = 34'sd2147483648;

  // Control state
  jddq_pkg::state_t state_r, state_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_acc_r;
  logic [10:0]      stick_r, dead_r;
  logic             dpad_r, auto_r;
  logic [4:0]       sector_r;
  logic signed [15:0]   last_vel_x_r, last_vel_y_r;
  logic signed [CW-1:0] last_thumb_x_r, last_thumb_y_r;

  // Datapath registers
  logic [1:0]            op_r;
  logic signed [CW-1:0]  px_r, py_r;
  logic [CMP_W-1:0]      dsq_r, rsq_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [ZW-1:0]  z_r;
  logic                  flip_r, clamped_r;
  logic [31:0]           t_r;
  logic [SQ_W-1:0]       rem_r;
  logic [QW-1:0]         quo_r;
  logic [SRC_W-1:0]      src_r;
  logic                  res_acc_r;
  logic signed [15:0]    res_vel_x_r, res_vel_y_r;
  logic signed [CW-1:0]  res_thumb_x_r, res_thumb_y_r;

  // Handshake and control decode
  logic in_fire, commit, reject, in_dead;
  logic vec_last, div_last, sqrt_last;

  // Shared units
  logic [CW-1:0]           ax, ay;
  logic [4:0]              n_eff;
  logic signed [DIST_W:0]  mul_a;
  logic signed [XY_W-1:0]  mul_b;
  logic signed [PW-1:0]    prod_nxt;
  logic [4:0]              sh;
  logic signed [XY_W-1:0]  xs, ys, x_step, y_step;
  logic signed [ZW-1:0]    at, z_step;
  logic                    s_pos;
  logic                    is_div;
  logic [SQ_W-1:0]         rem_sh, trial, rem_step;
  logic                    ge;
  logic [QW-1:0]           quo_step;
  logic [SRC_W-1:0]        src_step;
  logic [jddq_pkg::DIV_W-1:0] snap_rnd, dividend;
  logic signed [ZW-1:0]    zt;
  logic signed [CW+15:0]   xw, yw;
  logic [DIST_W-1:0]       radial_len;

  function automatic logic [15:0] vel_of(input logic signed [XY_W-1:0] c);
    logic signed [XY_W:0] s;
    s = (XY_W+1)'(c) + (XY_W+1)'(32768);
    s = s >>> 16;
    if (s > (XY_W+1)'(16384)) begin
      return 16'sd16384;
    end else if (s < -((XY_W+1)'(16384))) begin
      return -16'sd16384;
    end
    return s[15:0];
  endfunction

  // Round half away from zero after dropping 38 fraction bits, saturate to CW bits
  function automatic logic [CW-1:0] thumb_of(input logic signed [PW-1:0] p);
    logic [PW-1:0]  mag;
    logic [PW:0]    rnd;
    logic [PW-38:0] v;
    logic [PW-38:0] lim;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    rnd = (PW+1)'(mag) + (PW+1)'({1'b1, 37'd0});
    v   = rnd[PW:38];
    lim = (PW-37)'(1) << (CW-1);
    if (!p[PW-1]) begin
      if (v > lim - (PW-37)'(1)) begin
        return {1'b0, {(CW-1){1'b1}}};
      end
      return v[CW-1:0];
    end
    if (v > lim) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return -v[CW-1:0];
  endfunction

  // Decode
  assign in_fire   = in_tvalid && in_tready;
  assign commit    = !out_valid_r || out_tready;
  assign reject    = (op_r == jddq_pkg::OP_INVALID) ||
                     ((op_r == jddq_pkg::OP_BEGAN) && (dsq_r > rsq_r));
  assign in_dead   = dsq_r <= CMP_W'(prod_r);
  assign vec_last  = cnt_r == 6'(CORDIC_STEPS - 1);
  assign div_last  = cnt_r == 6'(jddq_pkg::DIV_STEPS - 1);
  assign sqrt_last = cnt_r == 6'(SQRT_STEPS - 1);

  assign ax    = px_r[CW-1] ? CW'(-px_r) : CW'(px_r);
  assign ay    = py_r[CW-1] ? CW'(-py_r) : CW'(py_r);
  assign n_eff = (sector_r == 5'd0) ? 5'd1 : sector_r;
  assign radial_len = clamped_r ? DIST_W'({stick_r, 8'd0})
                                : DIST_W'(quo_r[SQRT_STEPS-1:0]);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      jddq_pkg::S_SQX: begin
        mul_a = $signed({1'b0, DIST_W'(ax)});
        mul_b = $signed(XY_W'(ax));
      end
      jddq_pkg::S_SQY: begin
        mul_a = $signed({1'b0, DIST_W'(ay)});
        mul_b = $signed(XY_W'(ay));
      end
      jddq_pkg::S_SQR: begin
        mul_a = $signed({1'b0, DIST_W'(stick_r)});
        mul_b = $signed(XY_W'(stick_r));
      end
      jddq_pkg::S_SQD: begin
        mul_a = $signed({1'b0, DIST_W'(dead_r)});
        mul_b = $signed(XY_W'(dead_r));
      end
      jddq_pkg::S_DMUL: begin
        mul_a = $signed({1'b0, DIST_W'(n_eff)});
        mul_b = $signed(XY_W'(t_r));
      end
      jddq_pkg::S_TMX: begin
        mul_a = $signed({1'b0, radial_len});
        mul_b = x_r;
      end
      jddq_pkg::S_TMY: begin
        mul_a = $signed({1'b0, radial_len});
        mul_b = y_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Shared CORDIC step: vectoring steers by the sign of y, rotation by the sign of z
  assign sh     = cnt_r[4:0];
  assign xs     = x_r >>> sh;
  assign ys     = y_r >>> sh;
  assign at     = $signed({2'b00, jddq_pkg::atan_turn(sh)});
  assign s_pos  = (state_r == jddq_pkg::S_VEC) ? y_r[XY_W-1] : !z_r[ZW-1];
  assign x_step = s_pos ? x_r - ys : x_r + ys;
  assign y_step = s_pos ? y_r + xs : y_r - xs;
  assign z_step = s_pos ? z_r - at : z_r + at;

  // Shared compare-subtract: restoring divider (one bit) or square root (two bits)
  assign is_div   = state_r == jddq_pkg::S_DIV;
  assign rem_sh   = is_div ? {rem_r[SQ_W-2:0], src_r[SRC_W-1]}
                           : {rem_r[SQ_W-3:0], src_r[SRC_W-1 -: 2]};
  assign trial    = is_div ? SQ_W'(n_eff) : {quo_r[SQ_W-3:0], 2'b01};
  assign ge       = rem_sh >= trial;
  assign rem_step = ge ? rem_sh - trial : rem_sh;
  assign quo_step = {quo_r[QW-2:0], ge};
  assign src_step = is_div ? src_r << 1 : src_r << 2;

  // Sector snap: k = round(t * n / 2^32), dividend = k * 2^32 + n / 2
  assign snap_rnd = prod_r[jddq_pkg::DIV_W-1:0] + jddq_pkg::DIV_W'({1'b1, 31'd0});
  assign dividend = {snap_rnd[jddq_pkg::DIV_W-1:32], 32'd0} +
                    jddq_pkg::DIV_W'(n_eff >> 1);

  assign zt = $signed({{2{t_r[31]}}, t_r});
  assign xw = {px_r, 16'd0};
  assign yw = {py_r, 16'd0};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jddq_pkg::S_IDLE:   if (in_fire) state_nxt = jddq_pkg::S_SQX;
      jddq_pkg::S_SQX:    state_nxt = jddq_pkg::S_SQY;
      jddq_pkg::S_SQY:    state_nxt = jddq_pkg::S_SQR;
      jddq_pkg::S_SQR:    state_nxt = jddq_pkg::S_SQD;
      jddq_pkg::S_SQD:    state_nxt = jddq_pkg::S_DECIDE;
      jddq_pkg::S_DECIDE: begin
        state_nxt = (reject || in_dead) ? jddq_pkg::S_DONE : jddq_pkg::S_VEC;
      end
      jddq_pkg::S_VEC: begin
        if (vec_last) state_nxt = dpad_r ? jddq_pkg::S_DMUL : jddq_pkg::S_RSET;
      end
      jddq_pkg::S_DMUL:   state_nxt = jddq_pkg::S_DSET;
      jddq_pkg::S_DSET:   state_nxt = jddq_pkg::S_DIV;
      jddq_pkg::S_DIV:    if (div_last) state_nxt = jddq_pkg::S_RSET;
      jddq_pkg::S_RSET:   state_nxt = jddq_pkg::S_ROT;
      jddq_pkg::S_ROT:    if (vec_last) state_nxt = jddq_pkg::S_VEL;
      jddq_pkg::S_VEL: begin
        if (clamped_r && stick_r == 11'd0) begin
          state_nxt = jddq_pkg::S_DONE;
        end else if (!clamped_r && !dpad_r) begin
          state_nxt = jddq_pkg::S_DONE;
        end else if (clamped_r) begin
          state_nxt = jddq_pkg::S_TMX;
        end else begin
          state_nxt = jddq_pkg::S_SQRT;
        end
      end
      jddq_pkg::S_SQRT:   if (sqrt_last) state_nxt = jddq_pkg::S_TMX;
      jddq_pkg::S_TMX:    state_nxt = jddq_pkg::S_TMY;
      jddq_pkg::S_TMY:    state_nxt = jddq_pkg::S_TFIN;
      jddq_pkg::S_TFIN:   state_nxt = jddq_pkg::S_DONE;
      jddq_pkg::S_DONE:   if (commit) state_nxt = jddq_pkg::S_IDLE;
      default:            state_nxt = jddq_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs and control next values
  always_comb begin
    in_tready = state_r == jddq_pkg::S_IDLE;
    cfg_ready = 1'b1;
    cnt_nxt   = (state_nxt != state_r) ? 6'd0 : cnt_r + 6'd1;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == jddq_pkg::S_DONE && commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_acc_r;
  assign out_tdata  = OUT_W'({last_thumb_y_r, last_thumb_x_r, last_vel_y_r, last_vel_x_r});

  // Control registers, configuration and held result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= jddq_pkg::S_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      out_acc_r      <= 1'b0;
      stick_r        <= jddq_pkg::STICK_RADIUS_RST;
      dead_r         <= jddq_pkg::DEAD_RADIUS_RST;
      dpad_r         <= 1'b0;
      sector_r       <= jddq_pkg::SECTOR_COUNT_RST;
      auto_r         <= 1'b0;
      last_vel_x_r   <= '0;
      last_vel_y_r   <= '0;
      last_thumb_x_r <= '0;
      last_thumb_y_r <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          jddq_pkg::REG_STICK_RADIUS: stick_r  <= cfg_data;
          jddq_pkg::REG_DEAD_RADIUS:  dead_r   <= cfg_data;
          jddq_pkg::REG_DPAD_ENABLE:  dpad_r   <= cfg_data[0];
          jddq_pkg::REG_SECTOR_COUNT: sector_r <= cfg_data[4:0];
          jddq_pkg::REG_AUTO_CENTER:  auto_r   <= cfg_data[0];
          default: ;
        endcase
      end
      // Publish the result; a rejected event keeps the held velocity and thumb
      if (state_r == jddq_pkg::S_DONE && commit) begin
        out_acc_r <= res_acc_r;
        if (res_acc_r) begin
          last_vel_x_r   <= res_vel_x_r;
          last_vel_y_r   <= res_vel_y_r;
          last_thumb_x_r <= res_thumb_x_r;
          last_thumb_y_r <= res_thumb_y_r;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (state_r)
      jddq_pkg::S_IDLE: begin
        if (in_fire) begin
          op_r <= in_tuser;
          if (in_tuser == jddq_pkg::OP_ENDED && auto_r) begin
            px_r <= '0;
            py_r <= '0;
          end else begin
            px_r <= in_tdata[CW-1:0];
            py_r <= in_tdata[2*CW-1:CW];
          end
        end
      end
      jddq_pkg::S_SQY: dsq_r <= CMP_W'(prod_r);
      jddq_pkg::S_SQR: dsq_r <= dsq_r + CMP_W'(prod_r);
      jddq_pkg::S_SQD: rsq_r <= CMP_W'(prod_r);
      jddq_pkg::S_DECIDE: begin
        res_acc_r     <= !reject;
        clamped_r     <= dsq_r > rsq_r;
        res_vel_x_r   <= '0;
        res_vel_y_r   <= '0;
        res_thumb_x_r <= px_r;
        res_thumb_y_r <= py_r;
        // Start vectoring in the right half plane
        if (px_r[CW-1]) begin
          x_r <= -XY_W'(xw);
          y_r <= -XY_W'(yw);
          z_r <= H_TURN;
        end else begin
          x_r <= XY_W'(xw);
          y_r <= XY_W'(yw);
          z_r <= '0;
        end
      end
      jddq_pkg::S_VEC: begin
        x_r <= x_step;
        y_r <= y_step;
        z_r <= z_step;
        if (vec_last) t_r <= z_step[31:0];
      end
      jddq_pkg::S_DSET: begin
        rem_r <= '0;
        quo_r <= '0;
        src_r <= SRC_W'(dividend) << (SRC_W - jddq_pkg::DIV_W);
      end
      jddq_pkg::S_DIV: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        src_r <= src_step;
        if (div_last) t_r <= quo_step[31:0];
      end
      jddq_pkg::S_RSET: begin
        x_r <= $signed(XY_W'(jddq_pkg::CORDIC_INV_GAIN));
        y_r <= '0;
        // Fold the angle into the right half plane, negate the result at the end
        if (zt > Q_TURN) begin
          z_r    <= zt - H_TURN;
          flip_r <= 1'b1;
        end else if (zt < -Q_TURN) begin
          z_r    <= zt + H_TURN;
          flip_r <= 1'b1;
        end else begin
          z_r    <= zt;
          flip_r <= 1'b0;
        end
      end
      jddq_pkg::S_ROT: begin
        z_r <= z_step;
        if (vec_last && flip_r) begin
          x_r <= -x_step;
          y_r <= -y_step;
        end else begin
          x_r <= x_step;
          y_r <= y_step;
        end
      end
      jddq_pkg::S_VEL: begin
        if (clamped_r && stick_r == 11'd0) begin
          res_vel_x_r   <= '0;
          res_vel_y_r   <= '0;
          res_thumb_x_r <= '0;
          res_thumb_y_r <= '0;
        end else begin
          res_vel_x_r <= vel_of(x_r);
          res_vel_y_r <= vel_of(y_r);
        end
        rem_r <= '0;
        quo_r <= '0;
        src_r <= SRC_W'({dsq_r[2*CW-1:0], 16'd0}) << (SRC_W - RW);
      end
      jddq_pkg::S_SQRT: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        src_r <= src_step;
      end
      jddq_pkg::S_TMY:  res_thumb_x_r <= thumb_of(prod_r);
      jddq_pkg::S_TFIN: res_thumb_y_r <= thumb_of(prod_r);
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == jddq_pkg::S_IDLE && !out_valid_r))
    else $error("sequencer not idle after reset");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == jddq_pkg::S_SQX)
    else $error("accepted event did not start the sequence");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jddq_pkg::S_DONE && commit && !res_acc_r) |=>
      ($stable(last_vel_x_r) && $stable(last_vel_y_r) &&
       $stable(last_thumb_x_r) && $stable(last_thumb_y_r)))
    else $error("rejected event changed the held result");

  a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == jddq_pkg::S_VEC || state_r == jddq_pkg::S_ROT) |->
      cnt_r < 6'(CORDIC_STEPS))
    else $error("CORDIC step count overrun");

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_vel_x_r <= 16'sd16384 && last_vel_x_r >= -16'sd16384 &&
                     last_vel_y_r <= 16'sd16384 && last_vel_y_r >= -16'sd16384))
    else $error("velocity outside unit range");
`endif

endmodule
